/* design/ahsf_pkg.sv */
// Shared constants and types for the adaptive hue skin filter.
// No dependencies; the filter, the divider and the testbench import this package.
package ahsf_pkg;

    localparam int FRAME_PIXELS = 131072;
    localparam int POS_W        = $clog2(FRAME_PIXELS);
    localparam int HUE_BINS     = 32;
    localparam int BIN_W        = $clog2(HUE_BINS);
    localparam int CNT_W        = 18;
    localparam int ONE_W        = 17;                    // holds 65536
    localparam int QUO_W        = 17;                    // blended bin <= 65536
    localparam int DIVD_W       = CNT_W + ONE_W;         // count * weight
    localparam int TOT_W        = CNT_W + $clog2(HUE_BINS);
    localparam int TGT_W        = TOT_W + ONE_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [ONE_W-1:0] ONE_Q16   = ONE_W'(65536);
    localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(HUE_BINS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALUE_LOW  = 3'd0,
        CFG_VALUE_HIGH = 3'd1,
        CFG_HUE_LOW    = 3'd2,
        CFG_HUE_HIGH   = 3'd3,
        CFG_MOTION_THR = 3'd4,
        CFG_MERGE_W    = 3'd5,
        CFG_TAIL_FRAC  = 3'd6
    } t_cfg_idx;

    typedef logic [CNT_W-1:0] t_count;

endpackage

/* design/ahsf_pix_if.sv */
// Pixel input channel: valid/ready handshake with hue, value, frame marker.
// No dependencies.
interface ahsf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_hue;
    logic [7:0] pixel_value;
    logic       frame_end;

    modport source (output valid, pixel_hue, pixel_value, frame_end, input ready);
    modport sink   (input valid, pixel_hue, pixel_value, frame_end, output ready);
endinterface

/* design/ahsf_res_if.sv */
// Result channel: valid/ready handshake with skin hue and band limits.
// No dependencies.
interface ahsf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] skin_hue;
    logic [7:0] band_low;
    logic [7:0] band_high;

    modport source (output valid, skin_hue, band_low, band_high, input ready);
    modport sink   (input valid, skin_hue, band_low, band_high, output ready);
endinterface

/* design/adaptive_hue_skin_filter.sv */
// Adaptive hue skin filter: HSV pixel stream in, skin hue and band out.
// Pixel taken in S_IDLE; S_PIX (RAM read then update) registers its result once the
// output is free; next pixel waits for it. Frame end: maxima, blend (17-step dividers;
// none if no motion), sum, targets, walk. Reset: synchronous active-low; a clearing pass
// zeroes the previous-value RAM, taking no pixel meanwhile; config is always taken.
// Depends on ahsf_pkg, ahsf_pix_if, ahsf_res_if, ahsf_ram, ahsf_div.
module adaptive_hue_skin_filter import ahsf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ahsf_pix_if.sink              i_pix,
    ahsf_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_PIX, S_MAX, S_CHK, S_MUL, S_DIV, S_SUM, S_TGT, S_WALK
    } t_state;

    t_state r_state;

    // configuration registers
    logic [7:0]  r_value_low, r_value_high, r_hue_low, r_hue_high, r_motion_thr;
    logic [15:0] r_merge_w, r_tail_frac;

    // pixel state
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_h, r_v;
    logic             r_fe;
    logic             r_first;
    logic [7:0]       r_band_lo, r_band_hi;
    t_count           r_skin [HUE_BINS];
    t_count           r_motion [HUE_BINS];

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_skin, r_out_lo, r_out_hi;

    // frame-end processing
    logic [BIN_W-1:0]  r_k;
    t_count            r_max_s, r_max_m;
    logic [DIVD_W-1:0] r_pa, r_pb;
    logic              r_div_go;
    logic [TOT_W-1:0]  r_total, r_cum;
    logic [TGT_W-1:0]  r_tgt_lo, r_tgt_hi;
    logic              r_found_lo, r_found_hi;

    logic [7:0] prev_v;
    logic       ram_we;
    logic [7:0] ram_wdata;

    ahsf_ram #(.WIDTH(8), .DEPTH(FRAME_PIXELS)) u_prev (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (prev_v)
    );

    logic             done_a, done_b;
    logic [QUO_W-1:0] quo_a, quo_b;

    ahsf_div u_div_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_div_go),
        .i_dividend(r_pa), .i_divisor(r_max_s), .o_done(done_a), .o_quotient(quo_a)
    );
    ahsf_div u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_div_go),
        .i_dividend(r_pb), .i_divisor(r_max_m), .o_done(done_b), .o_quotient(quo_b)
    );

    // pixel decode
    logic             hue_ok, val_ok, bin_ok, moving, in_band, out_free, pix_go;
    logic [7:0]       bin8, diff;
    logic [BIN_W-1:0] bin;
    t_count           skin_at_bin, motion_at_bin, skin_k, motion_k;

    assign hue_ok   = (r_h >= r_hue_low) && (r_h <= r_hue_high);
    assign val_ok   = (r_v >= r_value_low) && (r_v <= r_value_high);
    assign bin8     = r_h - r_hue_low;
    assign bin_ok   = hue_ok && (bin8 < 8'(HUE_BINS));
    assign bin      = bin8[BIN_W-1:0];
    assign diff     = (r_v > prev_v) ? r_v - prev_v : prev_v - r_v;
    assign moving   = diff > r_motion_thr;
    assign in_band  = (r_h >= r_band_lo) && (r_h <= r_band_hi);
    assign out_free = !r_out_valid || o_res.ready;
    assign pix_go   = (r_state == S_PIX) && out_free;

    assign skin_at_bin   = r_skin[bin];
    assign motion_at_bin = r_motion[bin];
    assign skin_k        = r_skin[r_k];
    assign motion_k      = r_motion[r_k];

    assign ram_we    = (r_state == S_CLR) || pix_go;
    assign ram_wdata = (r_state == S_CLR) ? 8'd0 : r_v;

    // coverage walk: cumulative sum including the current bin
    logic [TOT_W-1:0] cum_n;
    logic [TGT_W-1:0] cum_q16;
    logic             hit_lo, hit_hi;
    logic [7:0]       lim_k;

    assign cum_n   = r_cum + TOT_W'(skin_k);
    assign cum_q16 = {cum_n, 16'd0};
    assign hit_lo  = !r_found_lo && (cum_q16 >= r_tgt_lo);
    assign hit_hi  = !r_found_hi && (cum_q16 >= r_tgt_hi);
    assign lim_k   = r_hue_low + 8'(r_k);

    // configuration writes, legal only while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_low  <= 8'd15;
            r_value_high <= 8'd250;
            r_hue_low    <= 8'd3;
            r_hue_high   <= 8'd33;
            r_motion_thr <= 8'd7;
            r_merge_w    <= 16'd3277;
            r_tail_frac  <= 16'd3277;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VALUE_LOW:  r_value_low  <= i_cfg_data[7:0];
                CFG_VALUE_HIGH: r_value_high <= i_cfg_data[7:0];
                CFG_HUE_LOW:    r_hue_low    <= i_cfg_data[7:0];
                CFG_HUE_HIGH:   r_hue_high   <= i_cfg_data[7:0];
                CFG_MOTION_THR: r_motion_thr <= i_cfg_data[7:0];
                CFG_MERGE_W:    r_merge_w    <= i_cfg_data;
                CFG_TAIL_FRAC:  r_tail_frac  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_pos       <= '0;
            r_first     <= 1'b1;
            r_band_lo   <= 8'd3;
            r_band_hi   <= 8'd33;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
            for (int i = 0; i < HUE_BINS; i++) begin
                r_skin[i]   <= '0;
                r_motion[i] <= '0;
            end
        end else begin
            // dividers start the cycle after the products are registered
            r_div_go <= (r_state == S_MUL);
            if (o_res.valid && o_res.ready && !pix_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    // zero the previous-value RAM, address wraps back to 0
                    r_pos <= r_pos + POS_W'(1);
                    if (r_pos == {POS_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_pix.valid) begin
                        r_h     <= i_pix.pixel_hue;
                        r_v     <= i_pix.pixel_value;
                        r_fe    <= i_pix.frame_end;
                        r_state <= S_PIX;
                    end
                end
                S_PIX: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_skin  <= (hue_ok && val_ok && in_band) ? r_h : 8'd0;
                        r_out_lo    <= r_band_lo;
                        r_out_hi    <= r_band_hi;
                        if (r_first && bin_ok && skin_at_bin != COUNT_MAX) begin
                            r_skin[bin] <= skin_at_bin + CNT_W'(1);
                        end
                        if (val_ok && bin_ok && moving && motion_at_bin != COUNT_MAX) begin
                            r_motion[bin] <= motion_at_bin + CNT_W'(1);
                        end
                        r_pos <= r_fe ? '0 : r_pos + POS_W'(1);
                        if (r_fe) begin
                            r_k     <= '0;
                            r_max_s <= '0;
                            r_max_m <= '0;
                            r_state <= S_MAX;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MAX: begin
                    if (skin_k > r_max_s) r_max_s <= skin_k;
                    if (motion_k > r_max_m) r_max_m <= motion_k;
                    r_k <= r_k + BIN_W'(1);
                    if (r_k == LAST_BIN) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    // empty motion histogram leaves the skin histogram as is
                    r_k     <= '0;
                    r_total <= '0;
                    r_state <= (r_max_m != '0) ? S_MUL : S_SUM;
                end
                S_MUL: begin
                    r_pa     <= DIVD_W'(skin_k * (ONE_Q16 - ONE_W'(r_merge_w)));
                    r_pb     <= DIVD_W'(motion_k * ONE_W'(r_merge_w));
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (done_a && done_b) begin
                        r_skin[r_k] <= (r_max_s == '0) ? motion_k
                                     : CNT_W'(quo_a) + CNT_W'(quo_b);
                        r_k <= r_k + BIN_W'(1);
                        r_state <= (r_k == LAST_BIN) ? S_SUM : S_MUL;
                    end
                end
                S_SUM: begin
                    r_total <= r_total + TOT_W'(skin_k);
                    r_k     <= r_k + BIN_W'(1);
                    if (r_k == LAST_BIN) begin
                        r_state <= S_TGT;
                    end
                end
                S_TGT: begin
                    r_tgt_lo   <= TGT_W'(r_total * r_tail_frac);
                    r_tgt_hi   <= TGT_W'(r_total * (ONE_Q16 - ONE_W'(r_tail_frac)));
                    r_cum      <= '0;
                    r_found_lo <= 1'b0;
                    r_found_hi <= 1'b0;
                    r_state    <= S_WALK;
                end
                S_WALK: begin
                    r_cum <= cum_n;
                    if (hit_lo) begin
                        r_found_lo <= 1'b1;
                        r_band_lo  <= lim_k;
                    end
                    if (hit_hi) begin
                        r_found_hi <= 1'b1;
                        r_band_hi  <= lim_k;
                    end
                    r_k <= r_k + BIN_W'(1);
                    if (r_k == LAST_BIN) begin
                        // coverage never reached: fall back to the hue range
                        if (!r_found_lo && !hit_lo) r_band_lo <= r_hue_low;
                        if (!r_found_hi && !hit_hi) r_band_hi <= r_hue_high;
                        for (int i = 0; i < HUE_BINS; i++) begin
                            r_motion[i] <= '0;
                        end
                        r_first <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_pix.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.skin_hue  = r_out_skin;
    assign o_res.band_low  = r_out_lo;
    assign o_res.band_high = r_out_hi;
endmodule

/* design/ahsf_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ahsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/ahsf_div.sv */
// Restoring divider, one quotient bit per cycle; quotient must fit QUO_W.
// Depends on ahsf_pkg.
module ahsf_div import ahsf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quotient
);
    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [CNT_W:0]      r_rem;
    logic [QUO_W-1:0]    r_low;
    logic [QUO_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_div;
    logic [STEP_W-1:0]   r_steps;
    logic                r_busy;
    logic                r_done;
    logic [CNT_W:0]      trial;
    logic                fits;

    assign trial = {r_rem[CNT_W-1:0], r_low[QUO_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_rem   <= {1'b0, i_dividend[DIVD_W-1:QUO_W]};
                r_low   <= i_dividend[QUO_W-1:0];
                r_div   <= i_divisor;
                r_steps <= STEP_W'(QUO_W);
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_rem   <= fits ? trial - {1'b0, r_div} : trial;
                r_low   <= {r_low[QUO_W-2:0], 1'b0};
                r_quo   <= {r_quo[QUO_W-2:0], fits};
                r_steps <= r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

/* tb/adaptive_hue_skin_filter_tb.sv */
// Self-checking testbench for adaptive_hue_skin_filter: directed and random pixel frames.
// Holds its own model of the skin filter and adaptive hue band.
// Depends on ahsf_pkg, ahsf_pix_if, ahsf_res_if and the block under test.
module adaptive_hue_skin_filter_tb;
    import ahsf_pkg::*;

    // Settle time after the last result: covers the frame-end histogram walk.
    localparam int SETTLE_CYCLES  = 1200;
    // Cycles without any transfer before giving up.  It must cover the
    // RAM clearing pass after reset.
    localparam int WATCHDOG_LIMIT = 4 * FRAME_PIXELS;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] value;
        logic       frame_end;
    } t_pixel;

    typedef struct packed {
        logic [7:0] skin_hue;
        logic [7:0] band_low;
        logic [7:0] band_high;
    } t_skin_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ahsf_pix_if pix ();
    ahsf_res_if res ();

    adaptive_hue_skin_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix.sink),
        .o_res      (res.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter model: configuration copy and internal state
    // ------------------------------------------------------------------
    logic [7:0]  m_value_low, m_value_high, m_hue_low, m_hue_high, m_motion_thr;
    logic [15:0] m_merge_w, m_tail_frac;
    logic [7:0]  m_prev_value [FRAME_PIXELS];
    int unsigned m_pos;
    longint unsigned m_skin_hist   [HUE_BINS];
    longint unsigned m_motion_hist [HUE_BINS];
    logic [7:0]  m_band_low, m_band_high;
    bit          m_first_frame;

    t_skin_result expected_results [$];
    t_pixel       pending_pixels [$];

    int n_errors   = 0;
    int n_pixels   = 0;
    int n_results  = 0;
    int n_frames   = 0;
    int n_skin     = 0;
    int n_cfg      = 0;

    // generator-side previous values, to make still pixels likely
    logic [7:0] gen_last [64];
    int         gen_pos = 0;

    bit src_idle_on = 1'b0;
    bit snk_idle_on = 1'b0;

    function automatic void model_reset();
        m_value_low  = 8'd15;  m_value_high = 8'd250;
        m_hue_low    = 8'd3;   m_hue_high   = 8'd33;
        m_motion_thr = 8'd7;
        m_merge_w    = 16'd3277; m_tail_frac = 16'd3277;
        foreach (m_prev_value[i]) m_prev_value[i] = 8'd0;
        m_pos = 0;
        foreach (m_skin_hist[i]) begin
            m_skin_hist[i]   = 0;
            m_motion_hist[i] = 0;
        end
        m_band_low = 8'd3; m_band_high = 8'd33;
        m_first_frame = 1'b1;
    endfunction

    // saturating bin count; out-of-table bins are dropped
    function automatic void bump(ref longint unsigned hist [HUE_BINS], input int unsigned bin);
        if (bin < HUE_BINS && hist[bin] < COUNT_MAX)
            hist[bin]++;
    endfunction

    // first bin where the running sum covers the target
    function automatic logic [7:0] band_limit(longint unsigned target, logic [7:0] fallback);
        longint unsigned cum;
        cum = 0;
        for (int i = 0; i < HUE_BINS; i++) begin
            cum += m_skin_hist[i];
            if (cum * 65536 >= target)
                return 8'(m_hue_low + i);
        end
        return fallback;
    endfunction

    // histogram blend and band search at frame end
    function automatic void adapt_band();
        longint unsigned max_m, max_s, a, b, total;
        max_m = 0; max_s = 0; total = 0;
        foreach (m_motion_hist[i]) if (m_motion_hist[i] > max_m) max_m = m_motion_hist[i];
        foreach (m_skin_hist[i])   if (m_skin_hist[i] > max_s)   max_s = m_skin_hist[i];
        if (max_m > 0) begin
            for (int i = 0; i < HUE_BINS; i++) begin
                if (max_s == 0) begin
                    m_skin_hist[i] = m_motion_hist[i];
                end else begin
                    a = (m_skin_hist[i] * (65536 - longint'(m_merge_w))) / max_s;
                    b = (m_motion_hist[i] * longint'(m_merge_w)) / max_m;
                    m_skin_hist[i] = a + b;
                end
            end
        end
        foreach (m_skin_hist[i]) total += m_skin_hist[i];
        m_band_low  = band_limit(total * m_tail_frac, m_hue_low);
        m_band_high = band_limit(total * (65536 - longint'(m_tail_frac)), m_hue_high);
        foreach (m_motion_hist[i]) m_motion_hist[i] = 0;
        m_first_frame = 1'b0;
    endfunction

    function automatic t_skin_result filter_pixel(t_pixel p);
        t_skin_result r;
        bit hue_ok;
        int unsigned bin, diff;
        logic [7:0] prev;
        r.skin_hue  = 8'd0;
        r.band_low  = m_band_low;
        r.band_high = m_band_high;
        hue_ok = p.hue >= m_hue_low && p.hue <= m_hue_high;
        bin = hue_ok ? p.hue - m_hue_low : HUE_BINS;
        if (m_first_frame && hue_ok)
            bump(m_skin_hist, bin);
        if (hue_ok && p.value >= m_value_low && p.value <= m_value_high) begin
            prev = m_prev_value[m_pos];
            diff = (p.value > prev) ? p.value - prev : prev - p.value;
            if (p.hue >= m_band_low && p.hue <= m_band_high)
                r.skin_hue = p.hue;
            if (diff > m_motion_thr)
                bump(m_motion_hist, bin);
        end
        m_prev_value[m_pos] = p.value;
        m_pos = (p.frame_end || m_pos + 1 >= FRAME_PIXELS) ? 0 : m_pos + 1;
        if (p.frame_end)
            adapt_band();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: one queued pixel per transfer, random gaps
    // ------------------------------------------------------------------
    int src_gap = 0;
    t_skin_result drv_exp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid       <= 1'b0;
            pix.pixel_hue   <= 8'd0;
            pix.pixel_value <= 8'd0;
            pix.frame_end   <= 1'b0;
        end else begin
            if (pix.valid && pix.ready) begin
                drv_exp = filter_pixel({pix.pixel_hue, pix.pixel_value, pix.frame_end});
                expected_results.push_back(drv_exp);
                n_pixels++;
                if (pix.frame_end) n_frames++;
                if (drv_exp.skin_hue != 0) n_skin++;
            end
            if (!pix.valid || pix.ready) begin
                if (src_gap > 0) begin
                    src_gap     <= src_gap - 1;
                    pix.valid   <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    pix.pixel_hue   <= pending_pixels[0].hue;
                    pix.pixel_value <= pending_pixels[0].value;
                    pix.frame_end   <= pending_pixels[0].frame_end;
                    pix.valid       <= 1'b1;
                    void'(pending_pixels.pop_front());
                    src_gap <= src_idle_on ? $urandom_range(0, 19) : 0;
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stalls, compare against oldest expectation
    // ------------------------------------------------------------------
    int snk_gap = 0;
    t_skin_result mon_exp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result skin=%0d low=%0d high=%0d", $time,
                             res.skin_hue, res.band_low, res.band_high);
                    n_errors++;
                end else begin
                    mon_exp = expected_results.pop_front();
                    if (res.skin_hue !== mon_exp.skin_hue) begin
                        $display("%0t: skin_hue expected %0d actual %0d", $time,
                                 mon_exp.skin_hue, res.skin_hue);
                        n_errors++;
                    end
                    if (res.band_low !== mon_exp.band_low) begin
                        $display("%0t: band_low expected %0d actual %0d", $time,
                                 mon_exp.band_low, res.band_low);
                        n_errors++;
                    end
                    if (res.band_high !== mon_exp.band_high) begin
                        $display("%0t: band_high expected %0d actual %0d", $time,
                                 mon_exp.band_high, res.band_high);
                        n_errors++;
                    end
                end
                snk_gap = snk_idle_on ? $urandom_range(0, 19) : 0;
            end
            if (snk_gap > 0) begin
                snk_gap--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transfer of any kind
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("adaptive_hue_skin_filter_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_VALUE_LOW:  m_value_low  = data[7:0];
            CFG_VALUE_HIGH: m_value_high = data[7:0];
            CFG_HUE_LOW:    m_hue_low    = data[7:0];
            CFG_HUE_HIGH:   m_hue_high   = data[7:0];
            CFG_MOTION_THR: m_motion_thr = data[7:0];
            CFG_MERGE_W:    m_merge_w    = data;
            CFG_TAIL_FRAC:  m_tail_frac  = data;
            default: ;
        endcase
        n_cfg++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [7:0] vlo, logic [7:0] vhi, logic [7:0] hlo, logic [7:0] hhi,
                             logic [7:0] thr, logic [15:0] mw, logic [15:0] tf);
        write_reg(CFG_VALUE_LOW, 16'(vlo));
        write_reg(CFG_VALUE_HIGH, 16'(vhi));
        write_reg(CFG_HUE_LOW, 16'(hlo));
        write_reg(CFG_HUE_HIGH, 16'(hhi));
        write_reg(CFG_MOTION_THR, 16'(thr));
        write_reg(CFG_MERGE_W, mw);
        write_reg(CFG_TAIL_FRAC, tf);
    endtask

    // block idle: all pixels out, all results back, frame-end walk done
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || pix.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_pixel(int hue, int value, bit fe);
        t_pixel p;
        p.hue = 8'(hue); p.value = 8'(value); p.frame_end = fe;
        pending_pixels.push_back(p);
    endfunction

    // one well-formed frame; hues cluster around the configured range
    function automatic void add_frame(int len);
        int h, v, lo, hi;
        lo = (m_hue_low  > 4)   ? m_hue_low - 4 : 0;
        hi = (m_hue_high < 175) ? m_hue_high + 4 : 179;
        if (lo > hi) begin lo = 0; hi = 179; end
        gen_pos = 0;
        for (int i = 0; i < len; i++) begin
            h = ($urandom_range(0, 9) < 7) ? $urandom_range(lo, hi) : $urandom_range(0, 179);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v = gen_last[gen_pos % 64] + $urandom_range(0, 16) - 8;
                4:          v = $urandom_range(0, 1) ? 0 : 255;
                default:    v = $urandom_range(0, 255);
            endcase
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            gen_last[gen_pos % 64] = 8'(v);
            gen_pos++;
            add_pixel(h, v, i == len - 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int h_lo, h_hi;

    initial begin
        model_reset();
        foreach (gen_last[i]) gen_last[i] = 8'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed first frame at reset settings: range edges, value limits,
        // a hue on each side of the range, and the top of the hue scale.
        add_pixel(3, 15, 0);    add_pixel(33, 250, 0);   add_pixel(2, 100, 0);
        add_pixel(34, 100, 0);  add_pixel(3, 14, 0);     add_pixel(33, 251, 0);
        add_pixel(0, 0, 0);     add_pixel(179, 255, 0);  add_pixel(20, 128, 0);
        add_pixel(20, 128, 0);  add_pixel(10, 200, 0);   add_pixel(15, 77, 1);
        // Second frame: still pixels (same values) and moving ones, band now adapted.
        add_pixel(3, 15, 0);    add_pixel(33, 250, 0);   add_pixel(2, 100, 0);
        add_pixel(34, 100, 0);  add_pixel(3, 200, 0);    add_pixel(33, 10, 0);
        add_pixel(0, 0, 0);     add_pixel(179, 255, 0);  add_pixel(20, 135, 0);
        add_pixel(20, 128, 1);
        wait_idle();

        // Extreme settings: zero hue origin with all-still pixels, weights at
        // their bounds, a range wider than the table, inverted ranges.
        write_all(8'd0, 8'd255, 8'd0, 8'd31, 8'd255, 16'd0, 16'd0);
        add_frame(20); add_frame(20);
        wait_idle();
        write_all(8'd0, 8'd255, 8'd0, 8'd31, 8'd0, 16'd65535, 16'd32768);
        add_frame(30); add_frame(30);
        wait_idle();
        write_all(8'd0, 8'd255, 8'd0, 8'd179, 8'd0, 16'd32768, 16'd0);
        add_frame(40); add_frame(40);
        wait_idle();
        write_all(8'd200, 8'd100, 8'd40, 8'd10, 8'd3, 16'd1000, 16'd1000);
        add_frame(20);
        wait_idle();
        write_all(8'd10, 8'd245, 8'd148, 8'd179, 8'd5, 16'd20000, 16'd8000);
        add_frame(30); add_frame(30);
        wait_idle();

        // Random phases: mostly well-formed frames, new settings in between.
        for (int ph = 0; ph < 22; ph++) begin
            src_idle_on = $urandom_range(0, 3) != 0;
            snk_idle_on = $urandom_range(0, 3) != 0;
            h_lo = $urandom_range(0, 160);
            h_hi = h_lo + $urandom_range(0, 40);
            if (h_hi > 179) h_hi = 179;
            if ($urandom_range(0, 9) == 0) h_hi = $urandom_range(0, 179);
            write_all(8'($urandom_range(0, 60)), 8'($urandom_range(180, 255)),
                      8'(h_lo), 8'(h_hi), 8'($urandom_range(0, 30)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 32768)));
            for (int f = 0; f < 2; f++) add_frame($urandom_range(4, 30));
            // occasional noise: loose pixels without a frame marker
            if ($urandom_range(0, 3) == 0)
                for (int k = 0; k < 5; k++)
                    add_pixel($urandom_range(0, 179), $urandom_range(0, 255), 1'b0);
            wait_idle();
        end

        // Back to reset settings: a lone frame marker, then one more frame.
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        write_all(8'd15, 8'd250, 8'd3, 8'd33, 8'd7, 16'd3277, 16'd3277);
        add_pixel(10, 100, 1'b1);
        add_frame(16);
        wait_idle();

        $display("covered %0d pixels in %0d frames, %0d skin hits, %0d register writes",
                 n_pixels, n_frames, n_skin, n_cfg);
        $display("%0d results checked, %0d mismatches", n_results, n_errors);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("adaptive_hue_skin_filter_tb OK");
        else
            $display("adaptive_hue_skin_filter_tb NOT OK");
        $finish;
    end

endmodule

/* adaptive_hue_skin_filter.f */
design/ahsf_pkg.sv
design/ahsf_pix_if.sv
design/ahsf_res_if.sv
design/ahsf_ram.sv
design/ahsf_div.sv
design/adaptive_hue_skin_filter.sv
tb/adaptive_hue_skin_filter_tb.sv
